// ===== rtl/owkd_pkg.sv =====
// ----------------------------------------------------------------------------
// owkd_pkg
// Shared types and constants of the three-wheel omni drive unit: field
// layout of the stream ports, fixed-point constants, command and job codes.
// ----------------------------------------------------------------------------
package owkd_pkg;

  // stream layout
  localparam int unsigned IN_DATA_W     = 72;
  localparam int unsigned IN_USER_W     = 2;
  localparam int unsigned OUT_DATA_W    = 56;
  localparam int unsigned OUT_USER_W    = 1;
  localparam int unsigned DIR_W         = 2;
  localparam int unsigned DUTY_FIELD_W  = 16;
  localparam int unsigned WHEEL_FIELD_W = DIR_W + DUTY_FIELD_W;
  localparam int unsigned NUM_WHEELS    = 3;

  // configuration port
  localparam int unsigned CFG_INDEX_W  = 2;
  localparam int unsigned CFG_DATA_W   = 16;
  localparam int unsigned PWM_MAX_W    = 16;
  localparam int unsigned DEADBAND_W   = 15;
  localparam logic [CFG_INDEX_W-1:0] CFG_PWM_MAX  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_DEADBAND = 2'd1;
  localparam logic [PWM_MAX_W-1:0]   PWM_MAX_RST  = 16'd255;
  localparam logic [DEADBAND_W-1:0]  DEADBAND_RST = 15'd328;

  // fixed point, Q1.14 speeds and Q2.28 wheel sums
  localparam int unsigned Q_FRAC  = 14;
  localparam int unsigned MAG_W   = 31;
  localparam int unsigned SPD_W   = Q_FRAC + 1;
  localparam int unsigned PROD_W  = SPD_W + PWM_MAX_W;
  localparam logic signed [31:0]  COS30_Q14   = 32'sd14189;
  localparam logic [MAG_W-1:0]    ONE_Q28     = 31'd268435456;
  localparam logic [MAG_W-1:0]    SINGLE_FULL = 31'd255;

  // input command codes
  localparam logic [1:0] CMD_BODY  = 2'd0;
  localparam logic [1:0] CMD_WHEEL = 2'd1;
  localparam logic [1:0] CMD_STOP  = 2'd2;
  localparam logic [1:0] WHEEL_NONE = 2'd3;

  // direction codes
  localparam logic [DIR_W-1:0] DIR_COAST = 2'd0;
  localparam logic [DIR_W-1:0] DIR_FWD   = 2'd1;
  localparam logic [DIR_W-1:0] DIR_REV   = 2'd2;

  // top-level parameter defaults
  localparam int unsigned DUTY_WIDTH_DEF  = 16;
  localparam int unsigned QUEUE_DEPTH_DEF = 2;

  typedef enum logic [1:0] {
    JOB_BODY,
    JOB_WHEEL,
    JOB_STOP,
    JOB_HOLD
  } job_kind_e;

  typedef struct packed {
    job_kind_e                             kind;
    logic                                  ignored;
    logic [1:0]                            sel;
    logic                                  div_en;
    logic [MAG_W-1:0]                      divisor;
    logic [NUM_WHEELS-1:0][MAG_W-1:0]      mag;
    logic [NUM_WHEELS-1:0]                 neg;
  } job_t;

  typedef struct packed {
    logic [PWM_MAX_W-1:0]  pwm_max;
    logic [DEADBAND_W-1:0] deadband;
  } cfg_t;

endpackage

// ===== rtl/owkd_fifo.sv =====
// ----------------------------------------------------------------------------
// owkd_fifo
// Small job queue between the command front end and the wheel back end.
// ----------------------------------------------------------------------------
module owkd_fifo
  import owkd_pkg::*;
#(
  parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t data_i,
  output logic full_o,
  input  logic pop_i,
  output job_t data_o,
  output logic empty_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  job_t          mem_q [DEPTH];
  logic [AW-1:0] wr_ptr_q, wr_ptr_d;
  logic [AW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CW-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// ===== rtl/owkd_div.sv =====
// ----------------------------------------------------------------------------
// owkd_div
// Restoring divider for the wheel rescale: quotient of a * 2^14 / d for
// a <= d, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module owkd_div
  import owkd_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [MAG_W-1:0] a_i,
  input  logic [MAG_W-1:0] d_i,
  output logic             done_o,
  output logic [SPD_W-1:0] quo_o
);

  localparam int unsigned CNT_W = $clog2(SPD_W);

  logic             busy_q;
  logic             done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [MAG_W:0]   rem_q, rem_d;
  logic [MAG_W-1:0] d_q;
  logic [SPD_W-1:0] quo_q;
  logic             ge;
  logic [MAG_W:0]   diff;

  assign done_o = done_q;
  assign quo_o  = quo_q;

  // remainder stays below twice the divisor, so the shift never drops a bit
  always_comb begin
    diff  = rem_q - {1'b0, d_q};
    ge    = (rem_q >= {1'b0, d_q});
    rem_d = ge ? {diff[MAG_W-1:0], 1'b0} : {rem_q[MAG_W-1:0], 1'b0};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNT_W'(SPD_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= {1'b0, a_i};
      d_q   <= d_i;
      quo_q <= '0;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= {quo_q[SPD_W-2:0], ge};
    end
  end

endmodule

// ===== rtl/owkd_front.sv =====
// ----------------------------------------------------------------------------
// owkd_front
// Command front end: takes a command item, forms the three wheel sums,
// their magnitudes and the largest one, and queues a job for the back end.
// ----------------------------------------------------------------------------
module owkd_front
  import owkd_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_valid_i,
  output logic                 s_ready_o,
  input  logic [IN_DATA_W-1:0] s_data_i,
  input  logic [IN_USER_W-1:0] s_user_i,
  output logic                 push_o,
  output job_t                 job_o,
  input  logic                 full_i
);

  localparam logic [1:0] FS_IDLE = 2'd0;
  localparam logic [1:0] FS_SUM  = 2'd1;
  localparam logic [1:0] FS_MAG  = 2'd2;
  localparam logic [1:0] FS_PUSH = 2'd3;

  logic [1:0]        state_q, state_d;
  logic [1:0]        cmd_q;
  logic signed [15:0] vx_q, vy_q, w_q, whl_q;
  logic [1:0]        sel_q;
  logic signed [31:0] ws0_q, ws1_q, ws2_q;
  logic signed [31:0] ws0_d, ws1_d, ws2_d;
  logic signed [31:0] vx32, vy32, w32, cprod;
  logic [NUM_WHEELS-1:0][MAG_W-1:0] mag_q, mag_d;
  logic [NUM_WHEELS-1:0]            neg_q, neg_d;
  logic [MAG_W-1:0]  m01, mx;
  logic [7:0]        raw_a;
  logic [13:0]       raw_x64;
  logic [15:0]       raw_t;
  logic [SPD_W-1:0]  raw_spd;

  function automatic logic [MAG_W-1:0] mag_of(input logic signed [31:0] v);
    logic signed [31:0] t;
    t = v[31] ? -v : v;
    return t[MAG_W-1:0];
  endfunction

  assign s_ready_o = (state_q == FS_IDLE);
  assign push_o    = (state_q == FS_PUSH) && !full_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      FS_IDLE: if (s_valid_i) state_d = FS_SUM;
      FS_SUM:  state_d = FS_MAG;
      FS_MAG:  state_d = FS_PUSH;
      FS_PUSH: if (!full_i) state_d = FS_IDLE;
      default: state_d = FS_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FS_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // wheel sums in Q2.28
  always_comb begin
    vx32  = 32'(vx_q);
    vy32  = 32'(vy_q);
    w32   = 32'(w_q);
    cprod = vx32 * COS30_Q14;
    if (cmd_q == CMD_BODY) begin
      ws0_d = (vy32 + w32) <<< Q_FRAC;
      ws1_d = (w32 <<< Q_FRAC) - (vy32 <<< (Q_FRAC - 1)) - cprod;
      ws2_d = (w32 <<< Q_FRAC) - (vy32 <<< (Q_FRAC - 1)) + cprod;
    end else begin
      ws0_d = 32'(whl_q);
      ws1_d = '0;
      ws2_d = '0;
    end
  end

  always_comb begin
    mag_d[0] = mag_of(ws0_q);
    mag_d[1] = mag_of(ws1_q);
    mag_d[2] = mag_of(ws2_q);
    neg_d    = {ws2_q[31], ws1_q[31], ws0_q[31]};
  end

  // raw / 255 in Q1.14: 16384 = 64 * 255 + 64, so speed = 64a + floor(64a / 255)
  // and floor(y / 255) = (y + (y >> 8) + 1) >> 8 for y this small
  always_comb begin
    raw_a   = (mag_q[0] >= SINGLE_FULL) ? SINGLE_FULL[7:0] : mag_q[0][7:0];
    raw_x64 = {raw_a, 6'd0};
    raw_t   = {2'b00, raw_x64} + {10'd0, raw_x64[13:8]} + 16'd1;
    raw_spd = {1'b0, raw_x64} + {7'd0, raw_t[15:8]};
  end

  always_comb begin
    m01 = (mag_q[0] > mag_q[1]) ? mag_q[0] : mag_q[1];
    mx  = (m01 > mag_q[2]) ? m01 : mag_q[2];

    job_o.kind    = JOB_HOLD;
    job_o.ignored = 1'b0;
    job_o.sel     = sel_q;
    job_o.div_en  = 1'b0;
    job_o.divisor = mx;
    job_o.mag     = mag_q;
    job_o.neg     = neg_q;
    unique case (cmd_q)
      CMD_BODY: begin
        job_o.kind   = JOB_BODY;
        job_o.div_en = (mx > ONE_Q28);
      end
      CMD_WHEEL: begin
        if (sel_q == WHEEL_NONE) begin
          job_o.ignored = 1'b1;
        end else begin
          // raw speeds at or above full scale give exactly 1.0
          job_o.kind    = JOB_WHEEL;
          job_o.mag[0]  = MAG_W'({raw_spd, {Q_FRAC{1'b0}}});
        end
      end
      CMD_STOP: job_o.kind = JOB_STOP;
      default:  job_o.kind = JOB_HOLD;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (state_q == FS_IDLE && s_valid_i) begin
      cmd_q <= s_user_i;
      vx_q  <= s_data_i[15:0];
      vy_q  <= s_data_i[31:16];
      w_q   <= s_data_i[47:32];
      sel_q <= s_data_i[49:48];
      whl_q <= s_data_i[65:50];
    end
    if (state_q == FS_SUM) begin
      ws0_q <= ws0_d;
      ws1_q <= ws1_d;
      ws2_q <= ws2_d;
    end
    if (state_q == FS_MAG) begin
      mag_q <= mag_d;
      neg_q <= neg_d;
    end
  end

endmodule

// ===== rtl/owkd_back.sv =====
// ----------------------------------------------------------------------------
// owkd_back
// Wheel back end: runs each queued body or single-wheel job wheel by wheel
// through rescale, deadband, direction and duty, holds the wheel state and
// drives the result register.
// ----------------------------------------------------------------------------
module owkd_back
  import owkd_pkg::*;
#(
  parameter int unsigned DUTY_WIDTH = DUTY_WIDTH_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  cfg_t                  cfg_i,
  input  job_t                  job_i,
  input  logic                  empty_i,
  output logic                  pop_o,
  output logic                  m_valid_o,
  input  logic                  m_ready_i,
  output logic [OUT_DATA_W-1:0] m_data_o,
  output logic [OUT_USER_W-1:0] m_user_o
);

  localparam logic [2:0] BS_IDLE  = 3'd0;
  localparam logic [2:0] BS_LOAD  = 3'd1;
  localparam logic [2:0] BS_DIV   = 3'd2;
  localparam logic [2:0] BS_DRIVE = 3'd3;
  localparam logic [2:0] BS_MUL   = 3'd4;
  localparam logic [2:0] BS_WB    = 3'd5;
  localparam logic [2:0] BS_OUT   = 3'd6;

  localparam logic [DUTY_WIDTH-1:0] DUTY_LIM = {DUTY_WIDTH{1'b1}};

  logic [2:0]            state_q, state_d;
  job_t                  job_q;
  logic [1:0]            k_q;
  logic [1:0]            tgt;
  logic [SPD_W-1:0]      spd_q, amp_q, amp_d;
  logic [DIR_W-1:0]      dir_q, dir_d;
  logic [PROD_W-1:0]     prod_q;
  logic [SPD_W+1:0]      duty_raw;
  logic [DUTY_WIDTH-1:0] duty_d;
  logic [DIR_W-1:0]      held_dir_q  [NUM_WHEELS];
  logic [DUTY_WIDTH-1:0] held_duty_q [NUM_WHEELS];
  logic                  ign_q;
  logic                  out_valid_q;
  logic [OUT_DATA_W-1:0] out_data_q, out_data_d;
  logic                  out_load;
  logic                  last_wheel;
  logic                  div_start;
  logic                  div_done;
  logic [SPD_W-1:0]      div_quo;

  assign pop_o      = (state_q == BS_IDLE) && !empty_i;
  assign out_load   = (state_q == BS_OUT) && (!out_valid_q || m_ready_i);
  assign m_valid_o  = out_valid_q;
  assign m_data_o   = out_data_q;
  assign m_user_o   = OUT_USER_W'(ign_q);
  assign tgt        = (job_q.kind == JOB_WHEEL) ? job_q.sel : k_q;
  assign last_wheel = (job_q.kind == JOB_WHEEL) || (k_q == 2'(NUM_WHEELS - 1));
  assign div_start  = (state_q == BS_LOAD) && job_q.div_en;

  owkd_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .a_i     (job_q.mag[k_q]),
    .d_i     (job_q.divisor),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BS_IDLE: begin
        if (!empty_i) begin
          state_d = (job_i.kind == JOB_BODY || job_i.kind == JOB_WHEEL) ? BS_LOAD : BS_OUT;
        end
      end
      BS_LOAD:  state_d = job_q.div_en ? BS_DIV : BS_DRIVE;
      BS_DIV:   if (div_done) state_d = BS_DRIVE;
      BS_DRIVE: state_d = BS_MUL;
      BS_MUL:   state_d = BS_WB;
      BS_WB:    state_d = last_wheel ? BS_OUT : BS_LOAD;
      BS_OUT:   if (out_load) state_d = BS_IDLE;
      default:  state_d = BS_IDLE;
    endcase
  end

  // deadband and direction
  always_comb begin
    amp_d = (spd_q < SPD_W'(cfg_i.deadband)) ? '0 : spd_q;
    if (amp_d == '0) begin
      dir_d = DIR_COAST;
    end else if (job_q.neg[k_q]) begin
      dir_d = DIR_REV;
    end else begin
      dir_d = DIR_FWD;
    end
  end

  // duty = floor(amp * pwm_max / 2^14), saturated to the duty width
  always_comb begin
    duty_raw = prod_q[PROD_W-1:Q_FRAC];
    if (|duty_raw[SPD_W+1:DUTY_WIDTH]) begin
      duty_d = DUTY_LIM;
    end else begin
      duty_d = duty_raw[DUTY_WIDTH-1:0];
    end
  end

  always_comb begin
    logic [DUTY_FIELD_W-1:0] d16;
    out_data_d = '0;
    for (int i = 0; i < NUM_WHEELS; i++) begin
      d16 = '0;
      d16[DUTY_WIDTH-1:0] = held_duty_q[i];
      out_data_d[i*WHEEL_FIELD_W +: DIR_W]               = held_dir_q[i];
      out_data_d[i*WHEEL_FIELD_W + DIR_W +: DUTY_FIELD_W] = d16;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BS_IDLE;
      k_q         <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < NUM_WHEELS; i++) begin
        held_dir_q[i]  <= DIR_COAST;
        held_duty_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      if (pop_o) begin
        k_q <= '0;
        if (job_i.kind == JOB_STOP) begin
          for (int i = 0; i < NUM_WHEELS; i++) begin
            held_dir_q[i]  <= DIR_COAST;
            held_duty_q[i] <= '0;
          end
        end
      end
      if (state_q == BS_WB) begin
        held_dir_q[tgt]  <= dir_q;
        held_duty_q[tgt] <= duty_d;
        if (!last_wheel) begin
          k_q <= k_q + 1'b1;
        end
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      job_q <= job_i;
    end
    if (state_q == BS_LOAD && !job_q.div_en) begin
      // no rescale: plain truncation from Q2.28 to Q1.14
      spd_q <= job_q.mag[k_q][2*Q_FRAC:Q_FRAC];
    end else if (state_q == BS_DIV && div_done) begin
      spd_q <= div_quo;
    end
    if (state_q == BS_DRIVE) begin
      amp_q <= amp_d;
      dir_q <= dir_d;
    end
    if (state_q == BS_MUL) begin
      prod_q <= PROD_W'(amp_q) * PROD_W'(cfg_i.pwm_max);
    end
    if (out_load) begin
      out_data_q <= out_data_d;
      ign_q      <= job_q.ignored;
    end
  end

endmodule

// ===== rtl/omni_wheel_kinematics_drive_unit.sv =====
// ----------------------------------------------------------------------------
// omni_wheel_kinematics_drive_unit
// Three-wheel omni drive: inverse kinematics, rescale and PWM output stage.
// ----------------------------------------------------------------------------
// Commands enter on the s_axis channel (tuser = command code, tdata = speeds
// and wheel select); every command item yields one result item on m_axis
// with the held direction and duty of all three wheels and, in tuser, the
// flag for a single-wheel command that named no wheel. Registers pwm_max
// and deadband are written through the cfg channel, which is always ready.
// The front end takes a new item only once the last one has passed capture,
// wheel sums, magnitudes and the queue push, which waits while the queue is
// full. For each wheel the back end loads the speed, runs the shared
// restoring divider when a rescale is needed (fifteen quotient bits, one per
// cycle), then forms deadband and direction, the duty product and the wheel
// write-back; it pops a job before its wheels and loads the result register
// after them, and a stop or hold job goes straight to the result register.
// Reset clears the wheel state to coast with zero duty and loads
// pwm_max = 255 and deadband = 328. A stalled receiver holds the result
// register; the job queue keeps the front end taking items until it fills.
// ----------------------------------------------------------------------------
module omni_wheel_kinematics_drive_unit
  import owkd_pkg::*;
#(
  parameter int unsigned DUTY_WIDTH  = DUTY_WIDTH_DEF,
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // command stream
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // fwd_speed, strafe_speed, turn_rate, wheel_select, wheel_speed
  input  logic [IN_DATA_W-1:0]   s_axis_tdata,
  // command
  input  logic [IN_USER_W-1:0]   s_axis_tuser,
  // result stream
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // wheel0_dir, wheel0_duty, wheel1_dir, wheel1_duty, wheel2_dir, wheel2_duty
  output logic [OUT_DATA_W-1:0]  m_axis_tdata,
  // ignored
  output logic [OUT_USER_W-1:0]  m_axis_tuser,
  // configuration writes
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CFG_INDEX_W-1:0] cfg_index_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i
);

  cfg_t cfg_q;
  job_t front_job;
  job_t queue_job;
  logic push;
  logic pop;
  logic full;
  logic empty;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pwm_max  <= PWM_MAX_RST;
      cfg_q.deadband <= DEADBAND_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_PWM_MAX:  cfg_q.pwm_max  <= cfg_data_i;
        CFG_DEADBAND: cfg_q.deadband <= cfg_data_i[DEADBAND_W-1:0];
        default: begin
        end
      endcase
    end
  end

  owkd_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .s_data_i  (s_axis_tdata),
    .s_user_i  (s_axis_tuser),
    .push_o    (push),
    .job_o     (front_job),
    .full_i    (full)
  );

  owkd_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (front_job),
    .full_o  (full),
    .pop_i   (pop),
    .data_o  (queue_job),
    .empty_o (empty)
  );

  owkd_back #(
    .DUTY_WIDTH (DUTY_WIDTH)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .job_i     (queue_job),
    .empty_i   (empty),
    .pop_o     (pop),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .m_data_o  (m_axis_tdata),
    .m_user_o  (m_axis_tuser)
  );

endmodule

// ===== bench/omni_drive_checker.sv =====
// ----------------------------------------------------------------------------
// omni_drive_checker
// Watches the command, result and register channels of the omni drive unit.
// Keeps its own copy of the wheel state and registers, works out the wheel
// report each accepted command must produce, and compares every accepted
// result field by field against the oldest outstanding report.
// ----------------------------------------------------------------------------
module omni_drive_checker
  import owkd_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // command channel
  input  logic                   cmd_valid_i,
  input  logic                   cmd_ready_i,
  input  logic [IN_DATA_W-1:0]   cmd_data_i,
  input  logic [IN_USER_W-1:0]   cmd_user_i,
  // result channel
  input  logic                   res_valid_i,
  input  logic                   res_ready_i,
  input  logic [OUT_DATA_W-1:0]  res_data_i,
  input  logic [OUT_USER_W-1:0]  res_user_i,
  // register writes
  input  logic                   cfg_valid_i,
  input  logic                   cfg_ready_i,
  input  logic [CFG_INDEX_W-1:0] cfg_index_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i,
  output int                     fail_count_o,
  output int                     pending_o
);

  localparam longint QONE     = 64'sd16384;
  localparam longint QHALF    = 64'sd8192;
  localparam longint QCOS30   = 64'sd14189;
  localparam longint SUM_ONE  = 64'sd268435456;
  localparam longint RAW_FULL = 64'sd255;
  localparam longint DUTY_SAT = (64'sd1 <<< DUTY_WIDTH_DEF) - 64'sd1;

  typedef struct packed {
    logic [NUM_WHEELS-1:0][DIR_W-1:0]        dir;
    logic [NUM_WHEELS-1:0][DUTY_FIELD_W-1:0] duty;
    logic                                    ignored;
  } wheel_report_t;

  logic [PWM_MAX_W-1:0]    pwm_max_q;
  logic [DEADBAND_W-1:0]   deadband_q;
  logic [DIR_W-1:0]        wheel_dir_q  [NUM_WHEELS];
  logic [DUTY_FIELD_W-1:0] wheel_duty_q [NUM_WHEELS];
  wheel_report_t           reports_due_q[$];
  wheel_report_t           got;
  wheel_report_t           want;
  int                      fails;

  // clamp, deadband, direction and duty for one wheel
  function automatic void drive_stage(input int idx, input longint spd);
    longint mag;
    longint duty;
    if (spd > QONE) spd = QONE;
    if (spd < -QONE) spd = -QONE;
    mag = (spd < 0) ? -spd : spd;
    if (mag < longint'(deadband_q)) begin
      spd = 0;
      mag = 0;
    end
    if (spd > 0) wheel_dir_q[idx] = DIR_FWD;
    else if (spd < 0) wheel_dir_q[idx] = DIR_REV;
    else wheel_dir_q[idx] = DIR_COAST;
    duty = (mag * longint'(pwm_max_q)) / QONE;
    if (duty > DUTY_SAT) duty = DUTY_SAT;
    wheel_duty_q[idx] = duty[DUTY_FIELD_W-1:0];
  endfunction

  function automatic wheel_report_t predict_wheels(input logic [IN_USER_W-1:0] cmd,
                                                   input logic [IN_DATA_W-1:0] data);
    wheel_report_t rep;
    longint vx;
    longint vy;
    longint w;
    longint raw;
    longint sums[NUM_WHEELS];
    longint mx;
    longint a;
    longint q;
    rep = '0;
    vx  = longint'($signed(data[15:0]));
    vy  = longint'($signed(data[31:16]));
    w   = longint'($signed(data[47:32]));
    raw = longint'($signed(data[65:50]));
    case (cmd)
      CMD_BODY: begin
        sums[0] = (vy + w) * QONE;
        sums[1] = -vy * QHALF - vx * QCOS30 + w * QONE;
        sums[2] = -vy * QHALF + vx * QCOS30 + w * QONE;
        mx = 0;
        for (int i = 0; i < NUM_WHEELS; i++) begin
          a = (sums[i] < 0) ? -sums[i] : sums[i];
          if (a > mx) mx = a;
        end
        for (int i = 0; i < NUM_WHEELS; i++) begin
          a = (sums[i] < 0) ? -sums[i] : sums[i];
          // rescale all three by the largest sum once it passes 1.0
          q = (mx > SUM_ONE) ? (a * QONE) / mx : a / QONE;
          drive_stage(i, (sums[i] < 0) ? -q : q);
        end
      end
      CMD_WHEEL: begin
        if (data[49:48] == WHEEL_NONE) begin
          rep.ignored = 1'b1;
        end else begin
          a = (raw < 0) ? -raw : raw;
          q = (a * QONE) / RAW_FULL;
          drive_stage(int'(data[49:48]), (raw < 0) ? -q : q);
        end
      end
      CMD_STOP: begin
        for (int i = 0; i < NUM_WHEELS; i++) begin
          wheel_dir_q[i]  = DIR_COAST;
          wheel_duty_q[i] = '0;
        end
      end
      default: ;
    endcase
    for (int i = 0; i < NUM_WHEELS; i++) begin
      rep.dir[i]  = wheel_dir_q[i];
      rep.duty[i] = wheel_duty_q[i];
    end
    return rep;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pwm_max_q  = PWM_MAX_RST;
      deadband_q = DEADBAND_RST;
      for (int i = 0; i < NUM_WHEELS; i++) begin
        wheel_dir_q[i]  = DIR_COAST;
        wheel_duty_q[i] = '0;
      end
      reports_due_q.delete();
      fails = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (res_valid_i && res_ready_i) begin
        for (int i = 0; i < NUM_WHEELS; i++) begin
          got.dir[i]  = res_data_i[i*WHEEL_FIELD_W +: DIR_W];
          got.duty[i] = res_data_i[i*WHEEL_FIELD_W+DIR_W +: DUTY_FIELD_W];
        end
        got.ignored = res_user_i[0];
        if (reports_due_q.size() == 0) begin
          $error("result item with no command outstanding");
          fails++;
        end else begin
          want = reports_due_q.pop_front();
          for (int i = 0; i < NUM_WHEELS; i++) begin
            if (got.dir[i] !== want.dir[i]) begin
              $error("wheel%0d_dir: expected %0d, actual %0d", i, want.dir[i], got.dir[i]);
              fails++;
            end
            if (got.duty[i] !== want.duty[i]) begin
              $error("wheel%0d_duty: expected %0d, actual %0d", i, want.duty[i], got.duty[i]);
              fails++;
            end
          end
          if (got.ignored !== want.ignored) begin
            $error("ignored: expected %0d, actual %0d", want.ignored, got.ignored);
            fails++;
          end
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_index_i == CFG_PWM_MAX) pwm_max_q = cfg_data_i;
        else if (cfg_index_i == CFG_DEADBAND) deadband_q = cfg_data_i[DEADBAND_W-1:0];
      end
      if (cmd_valid_i && cmd_ready_i) begin
        reports_due_q.push_back(predict_wheels(cmd_user_i, cmd_data_i));
      end
      fail_count_o <= fails;
      pending_o    <= reports_due_q.size();
    end
  end

endmodule

// ===== bench/omni_wheel_kinematics_drive_unit_tb.sv =====
// ----------------------------------------------------------------------------
// omni_wheel_kinematics_drive_unit_tb
// Drives body velocity, single-wheel, stop and unused commands into the omni
// drive unit under several pwm_max and deadband settings, with random gaps on
// the command side and random back-pressure on the result side. A checker
// beside the unit predicts and compares every result item.
// ----------------------------------------------------------------------------
module omni_wheel_kinematics_drive_unit_tb
  import owkd_pkg::*;
();

  localparam logic [1:0] CMD_UNUSED  = 2'd3;
  localparam int         CYCLE_LIMIT = 1000000;
  localparam int         NUM_PHASES  = 8;
  localparam int         PHASE_ITEMS = 180;

  logic                   clk_i          = 1'b0;
  logic                   rst_ni         = 1'b0;
  logic                   s_axis_tvalid  = 1'b0;
  logic                   s_axis_tready;
  logic [IN_DATA_W-1:0]   s_axis_tdata   = '0;
  logic [IN_USER_W-1:0]   s_axis_tuser   = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready  = 1'b0;
  logic [OUT_DATA_W-1:0]  m_axis_tdata;
  logic [OUT_USER_W-1:0]  m_axis_tuser;
  logic                   cfg_valid_i    = 1'b0;
  logic                   cfg_ready_o;
  logic [CFG_INDEX_W-1:0] cfg_index_i    = '0;
  logic [CFG_DATA_W-1:0]  cfg_data_i     = '0;

  int fail_count;
  int pending;
  int cycles = 0;
  bit calm   = 1'b0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  omni_wheel_kinematics_drive_unit uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  omni_drive_checker checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_valid_i  (s_axis_tvalid),
    .cmd_ready_i  (s_axis_tready),
    .cmd_data_i   (s_axis_tdata),
    .cmd_user_i   (s_axis_tuser),
    .res_valid_i  (m_axis_tvalid),
    .res_ready_i  (m_axis_tready),
    .res_data_i   (m_axis_tdata),
    .res_user_i   (m_axis_tuser),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_i  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always @(posedge clk_i) begin
    m_axis_tready <= calm || ($urandom_range(99) >= 19);
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic logic [IN_DATA_W-1:0] pack_fields(input logic [15:0] fwd,
                                                       input logic [15:0] strafe,
                                                       input logic [15:0] turn,
                                                       input logic [1:0]  sel,
                                                       input logic [15:0] raw);
    return {6'd0, raw, sel, turn, strafe, fwd};
  endfunction

  // q1.14 speed: mostly in range, some extremes, some near the deadband
  function automatic logic [15:0] rand_speed();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 5) return 16'($urandom);
    if (pick < 15) begin
      case ($urandom_range(2))
        0: return 16'sd16384;
        1: return -16'sd16384;
        default: return 16'd0;
      endcase
    end
    if (pick < 27) return 16'(int'($urandom_range(1200)) - 600);
    return 16'(int'($urandom_range(32768)) - 16384);
  endfunction

  function automatic logic [15:0] rand_raw();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 25) return 16'(int'($urandom_range(600)) - 300);
    if (pick < 35) begin
      case ($urandom_range(4))
        0: return 16'sd32767;
        1: return -16'sd32768;
        2: return 16'sd255;
        3: return -16'sd255;
        default: return 16'd0;
      endcase
    end
    if (pick < 70) return 16'(int'($urandom_range(1020)) - 510);
    return 16'($urandom);
  endfunction

  task automatic send_cmd(input logic [1:0] cmd, input logic [IN_DATA_W-1:0] data);
    if (!calm) begin
      while ($urandom_range(99) < 19) begin
        s_axis_tvalid <= 1'b0;
        @(posedge clk_i);
      end
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= data;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  task automatic send_random();
    int unsigned pick;
    logic [1:0] cmd;
    pick = $urandom_range(99);
    if (pick < 52) cmd = CMD_BODY;
    else if (pick < 82) cmd = CMD_WHEEL;
    else if (pick < 92) cmd = CMD_STOP;
    else cmd = CMD_UNUSED;
    // unused fields carry random values, the unit must not look at them
    send_cmd(cmd, pack_fields(rand_speed(), rand_speed(), rand_speed(),
                              2'($urandom_range(3)), rand_raw()));
  endtask

  // stop sending and let every outstanding result come back
  task automatic drain(input int settle);
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (settle) @(posedge clk_i);
  endtask

  task automatic set_regs(input logic [15:0] pwm, input logic [15:0] dead);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= CFG_PWM_MAX;
    cfg_data_i  <= pwm;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_index_i <= CFG_DEADBAND;
    cfg_data_i  <= dead;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part, reset register values
    send_cmd(CMD_BODY,  pack_fields(16'd0, 16'd0, 16'd0, 2'd0, 16'd0));
    send_cmd(CMD_BODY,  pack_fields(16'sd16384, 16'd0, 16'd0, 2'd0, 16'd0));
    send_cmd(CMD_BODY,  pack_fields(16'd0, 16'sd16384, 16'sd16384, 2'd0, 16'd0));
    send_cmd(CMD_BODY,  pack_fields(-16'sd16384, -16'sd16384, -16'sd16384, 2'd0, 16'd0));
    send_cmd(CMD_BODY,  pack_fields(-16'sd16384, 16'sd16384, -16'sd16384, 2'd0, 16'd0));
    send_cmd(CMD_BODY,  pack_fields(16'd0, 16'sd100, 16'd0, 2'd0, 16'd0));
    send_cmd(CMD_BODY,  pack_fields(16'sd16384, 16'sd16384, 16'sd16384, 2'd0, 16'd0));
    send_cmd(CMD_WHEEL, pack_fields(16'd0, 16'd0, 16'd0, 2'd0, 16'sd255));
    send_cmd(CMD_WHEEL, pack_fields(16'd0, 16'd0, 16'd0, 2'd1, -16'sd255));
    send_cmd(CMD_WHEEL, pack_fields(16'd0, 16'd0, 16'd0, 2'd2, 16'sd32767));
    send_cmd(CMD_WHEEL, pack_fields(16'd0, 16'd0, 16'd0, 2'd0, -16'sd32768));
    send_cmd(CMD_WHEEL, pack_fields(16'd0, 16'd0, 16'd0, WHEEL_NONE, 16'sd100));
    send_cmd(CMD_WHEEL, pack_fields(16'd0, 16'd0, 16'd0, 2'd1, 16'sd5));
    send_cmd(CMD_UNUSED, pack_fields(16'hffff, 16'hffff, 16'hffff, 2'd2, 16'hffff));
    send_cmd(CMD_STOP,  pack_fields(16'hffff, 16'hffff, 16'hffff, 2'd3, 16'hffff));
    send_cmd(CMD_UNUSED, pack_fields(16'd0, 16'd0, 16'd0, 2'd0, 16'd0));
    send_cmd(CMD_BODY,  pack_fields(16'sd8000, -16'sd4000, 16'sd2000, WHEEL_NONE, 16'h8001));
    send_cmd(CMD_WHEEL, pack_fields(16'h7fff, 16'h8000, 16'h1234, 2'd2, -16'sd128));
    send_cmd(CMD_BODY,  pack_fields(-16'sd32768, -16'sd32768, -16'sd32768, 2'd1, 16'd0));
    send_cmd(CMD_BODY,  pack_fields(16'sd32767, 16'sd32767, 16'sd32767, 2'd2, 16'd0));
    send_cmd(CMD_WHEEL, pack_fields(16'd0, 16'd0, 16'd0, 2'd2, 16'd0));
    send_cmd(CMD_STOP,  pack_fields(16'd0, 16'd0, 16'd0, 2'd0, 16'd0));
    drain(80);

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0: set_regs(16'd65535, 16'd0);
        1: set_regs(16'd255, 16'd328);
        2: set_regs(16'd1, 16'd16384);
        3: set_regs(16'd0, 16'd500);
        4: set_regs(16'd40000, 16'd32767);  // deadband above full scale
        default: set_regs(16'($urandom), 16'($urandom_range(2000)));
      endcase
      calm = (ph == 1);
      repeat (PHASE_ITEMS) send_random();
      drain(80);
      calm = 1'b0;
    end

    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
